@@ rtl/gfe_pkg.sv @@
package gfe_pkg;

    // Operation codes carried in the op field of an input word.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ELIM  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_DONE,
        S_K,
        S_PIV,
        S_DJ,
        S_DREAD,
        S_DWAIT,
        S_I,
        S_FAC,
        S_J,
        S_JA,
        S_JB,
        S_JW
    } state_t;

    // Input word.
    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic               status;
    } out_word_t;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
            r = S32_MAX;
        else if (x < -64'sh0000_0000_8000_0000)
            r = S32_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

    // Saturate a 33-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        logic signed [31:0] r;
        if (x[32] != x[31])
            r = x[32] ? S32_MIN : S32_MAX;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

@@ rtl/gfe_div.sv @@
// Restoring divider: one quotient bit a cycle, (a * 2^FRAC_BITS) / p,
// truncated toward zero and saturated to 32 bits. The divisor is never zero.
module gfe_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] quotient
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [DW-1:0] POS_LIM = DW'(64'h7FFF_FFFF);
    localparam logic [DW-1:0] NEG_LIM = DW'(64'h8000_0000);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      dmag_reg, dmag_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      rem_sh;
    logic [31:0]      amag;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    // One restoring step a cycle while busy.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        amag      = dividend[31] ? 32'(-dividend) : 32'(dividend);
        rem_sh    = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            quo_next  = {amag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dmag_next = divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dmag_reg})
            begin
                rem_next = 32'(rem_sh - {1'b0, dmag_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Sign and saturation of the finished magnitude.
    always_comb
    begin
        if (neg_reg)
            quotient = (quo_reg > NEG_LIM) ? gfe_pkg::S32_MIN : 32'(-quo_reg[31:0]);
        else
            quotient = (quo_reg > POS_LIM) ? gfe_pkg::S32_MAX : quo_reg[31:0];
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

@@ rtl/gfe_mac.sv @@
// Multiply-subtract: c - floor(a * b / 2^FRAC_BITS), both steps saturated.
// The product is registered on load; the result is valid the cycle after.
module gfe_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               load,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] c,
    output logic signed [31:0] result
);

    logic signed [63:0] prod_reg;
    logic signed [31:0] c_reg;
    logic signed [63:0] scaled;
    logic signed [31:0] p32;

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= a * b;
            c_reg    <= c;
        end
    end

    // The arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        scaled = prod_reg >>> FRAC_BITS;
        p32    = gfe_pkg::sat64(scaled);
        result = gfe_pkg::sat33(33'(c_reg) - 33'(p32));
    end

endmodule

@@ rtl/gaussian_forward_elimination.sv @@
// Write and unused op words give a registered result; a read first passes
// through S_RD_DONE. Elimination of an n by n matrix runs each
// multiply-subtract (S_J, S_JA, S_JB, S_JW) and each division (S_DREAD, S_DWAIT) in turn,
// sharing the one divider and the matrix memory (one write and one read port).
// One word is handled at a time. Reset clears the sticky zero-pivot flag and
// sets the active size to 16; matrix contents are undefined until written.
module gaussian_forward_elimination #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  gfe_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output gfe_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_data
);

    localparam int IW = $clog2(MAX_SIZE);
    localparam int CW = $clog2(MAX_SIZE + 1);
    localparam int AW = 2 * IW;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    gfe_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic signed [31:0] piv_reg, piv_next, fac_reg, fac_next, a_reg, a_next;
    logic               flag_reg, flag_next;
    logic [4:0]         size_reg, size_next;
    logic               out_valid_reg, out_valid_next;
    gfe_pkg::out_word_t out_data_reg, out_data_next;

    logic signed [31:0] mem [2**AW];
    logic signed [31:0] rdata_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic               accept, in_range;
    logic [CW-1:0]      n_size;
    logic [AW-1:0]      port_addr;
    logic               div_start, div_busy, div_done;
    logic signed [31:0] div_q;
    logic               mac_load;
    logic signed [31:0] mac_res;

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return {r[IW-1:0], c[IW-1:0]};
    endfunction

    gfe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rdata_reg),
        .divisor  (piv_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    gfe_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk    (clk),
        .load   (mac_load),
        .a      (a_reg),
        .b      (fac_reg),
        .c      (rdata_reg),
        .result (mac_res)
    );

    // Matrix memory: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfe_pkg::S_IDLE;
            flag_reg      <= 1'b0;
            size_reg      <= 5'd16;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        piv_reg      <= piv_next;
        fac_reg      <= fac_next;
        a_reg        <= a_next;
        out_data_reg <= out_data_next;
    end

    // Handshake and index decoding.
    always_comb
    begin
        in_stall  = !(state_reg == gfe_pkg::S_IDLE && (!out_valid_reg || !out_stall));
        accept    = in_valid && !in_stall;
        in_range  = (in_data.row < MAX_SIZE) && (in_data.col < MAX_SIZE);
        port_addr = {IW'(in_data.row), IW'(in_data.col)};
        n_size    = ({27'd0, size_reg} > MAX_SIZE) ? CW'(MAX_SIZE) : CW'(size_reg);
    end

    // Sequencer: next state, counters and memory controls.
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        piv_next       = piv_reg;
        fac_next       = fac_reg;
        a_next         = a_reg;
        flag_next      = flag_reg;
        size_next      = cfg_we ? cfg_data : size_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;
        div_start      = 1'b0;
        mac_load       = 1'b0;
        unique case (state_reg)
            gfe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (gfe_pkg::op_t'(in_data.op))
                        gfe_pkg::OP_WRITE:
                        begin
                            mem_we         = in_range;
                            mem_waddr      = port_addr;
                            mem_wdata      = in_data.value;
                            out_valid_next = 1'b1;
                            out_data_next  = '{read_value: '0, status: flag_reg};
                        end
                        gfe_pkg::OP_ELIM:
                        begin
                            flag_next  = 1'b0;
                            k_next     = '0;
                            state_next = gfe_pkg::S_K;
                        end
                        gfe_pkg::OP_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = port_addr;
                            a_next     = in_range ? 32'sd1 : 32'sd0;
                            state_next = gfe_pkg::S_RD_DONE;
                        end
                        gfe_pkg::OP_NONE:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{read_value: '0, status: flag_reg};
                        end
                        default:
                        begin
                            state_next = gfe_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            // A read outside the store returns zero.
            gfe_pkg::S_RD_DONE:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{read_value: (a_reg[0] ? rdata_reg : 32'sd0),
                                   status: flag_reg};
                state_next     = gfe_pkg::S_IDLE;
            end
            // Next pivot row, or finish.
            gfe_pkg::S_K:
            begin
                if (k_reg >= n_size)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{read_value: '0, status: flag_reg};
                    state_next     = gfe_pkg::S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr(k_reg, k_reg);
                    state_next = gfe_pkg::S_PIV;
                end
            end
            gfe_pkg::S_PIV:
            begin
                piv_next   = rdata_reg;
                j_next     = k_reg + CW'(1);
                state_next = gfe_pkg::S_DJ;
            end
            // Scale the pivot row right of the diagonal, then set the diagonal to one.
            gfe_pkg::S_DJ:
            begin
                if (j_reg >= n_size)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = addr(k_reg, k_reg);
                    mem_wdata  = ONE;
                    i_next     = k_reg + CW'(1);
                    state_next = gfe_pkg::S_I;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr(k_reg, j_reg);
                    state_next = gfe_pkg::S_DREAD;
                end
            end
            gfe_pkg::S_DREAD:
            begin
                if (piv_reg == 32'sd0)
                begin
                    // Zero pivot: saturate by the dividend's sign.
                    flag_next  = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = addr(k_reg, j_reg);
                    if (rdata_reg > 32'sd0)
                        mem_wdata = gfe_pkg::S32_MAX;
                    else if (rdata_reg < 32'sd0)
                        mem_wdata = gfe_pkg::S32_MIN;
                    else
                        mem_wdata = 32'sd0;
                    j_next     = j_reg + CW'(1);
                    state_next = gfe_pkg::S_DJ;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = gfe_pkg::S_DWAIT;
                end
            end
            gfe_pkg::S_DWAIT:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = addr(k_reg, j_reg);
                    mem_wdata  = div_q;
                    j_next     = j_reg + CW'(1);
                    state_next = gfe_pkg::S_DJ;
                end
            end
            // Next lower row, or next pivot.
            gfe_pkg::S_I:
            begin
                if (i_reg >= n_size)
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = gfe_pkg::S_K;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr(i_reg, k_reg);
                    state_next = gfe_pkg::S_FAC;
                end
            end
            gfe_pkg::S_FAC:
            begin
                fac_next   = rdata_reg;
                j_next     = k_reg + CW'(1);
                state_next = gfe_pkg::S_J;
            end
            // Multiply-subtract across the row, then clear the pivot column.
            gfe_pkg::S_J:
            begin
                if (j_reg >= n_size)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = addr(i_reg, k_reg);
                    mem_wdata  = 32'sd0;
                    i_next     = i_reg + CW'(1);
                    state_next = gfe_pkg::S_I;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = addr(k_reg, j_reg);
                    state_next = gfe_pkg::S_JA;
                end
            end
            gfe_pkg::S_JA:
            begin
                a_next     = rdata_reg;
                mem_re     = 1'b1;
                mem_raddr  = addr(i_reg, j_reg);
                state_next = gfe_pkg::S_JB;
            end
            gfe_pkg::S_JB:
            begin
                mac_load   = 1'b1;
                state_next = gfe_pkg::S_JW;
            end
            gfe_pkg::S_JW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr(i_reg, j_reg);
                mem_wdata  = mac_res;
                j_next     = j_reg + CW'(1);
                state_next = gfe_pkg::S_J;
            end
            default:
            begin
                state_next = gfe_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The divider is never started on a zero pivot.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> piv_reg != 32'sd0)
        else $error("divider started on a zero pivot");

    // Starting an elimination clears the sticky flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.op == gfe_pkg::OP_ELIM) |=> !flag_reg)
        else $error("zero-pivot flag not cleared at elimination start");

    // The divider only runs while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == gfe_pkg::S_DWAIT)
        else $error("divider busy outside its wait state");

    // Words are only taken while no result is left blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!out_valid_reg || !out_stall))
        else $error("word accepted while a result is stalled");

endmodule
